@@ hdl/mahd_pkg.sv @@
// Shared types, constants and lookup tables for the MPEG audio header decoder.
// Depends on nothing; all but the two interface files use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mahd_pkg;

	localparam logic [7:0] SYNC_BYTE   = 8'hFF;
	localparam logic [3:0] SYNC_NIBBLE = 4'hF;
	localparam logic [6:0] MPEG25_L3   = 7'h71;
	localparam logic [7:0] MATCH_B1    = 8'hFE;
	localparam logic [7:0] MATCH_B2    = 8'h0C;
	localparam logic [3:0] BAD_BRI     = 4'd15;
	localparam logic [1:0] BAD_SRI     = 2'd3;
	localparam logic [1:0] MONO_MODE   = 2'd3;
	localparam logic [1:0] LAYER_I     = 2'd3;
	localparam logic [1:0] SRI_44K1    = 2'd0;
	localparam logic [1:0] SRI_32K     = 2'd2;

	localparam logic [15:0] HZ_44K1 = 16'd44100;
	localparam logic [15:0] HZ_48K  = 16'd48000;
	localparam logic [15:0] HZ_32K  = 16'd32000;

	localparam logic [10:0] SAMPLES_L1  = 11'd384;
	localparam logic [10:0] SAMPLES_LSF = 11'd576;
	localparam logic [10:0] SAMPLES_STD = 11'd1152;

	localparam logic [2:0] PAD_L1    = 3'd4;
	localparam logic [2:0] PAD_OTHER = 3'd1;

	// Frame bytes = kbps * scale / divisor, with the divisor 1, 2 or 147.
	localparam logic [10:0] SCALE_44K1 = 11'd160;
	localparam logic [10:0] SCALE_32K  = 11'd3;

	localparam int          RECIP_SHIFT = 26;
	localparam int          X_W         = 20;
	localparam int          RECIP_W     = 27;
	localparam int          PROD_W      = X_W + RECIP_W;
	localparam logic [26:0] RECIP_ONE   = 27'd67108864;
	localparam logic [26:0] RECIP_TWO   = 27'd33554432;
	localparam logic [26:0] RECIP_147   = 27'd456523;

	typedef enum logic [1:0] {
		DIV_ONE,
		DIV_TWO,
		DIV_147
	} div_sel_t;

	typedef struct packed {
		logic        ok;
		logic        ref_match;
		logic        layer1;
		logic [8:0]  kbps;
		logic [15:0] hz;
		logic [10:0] samples;
		logic [2:0]  padding;
		logic [1:0]  chans;
		logic [1:0]  layer_num;
		logic [10:0] scale;
		div_sel_t    div_sel;
	} hdr_info_t;

	localparam logic [7:0] HALF_KBPS [2][3][15] = '{
		'{ '{8'd0, 8'd4, 8'd8, 8'd12, 8'd16, 8'd20, 8'd24, 8'd28,
		     8'd32, 8'd40, 8'd48, 8'd56, 8'd64, 8'd72, 8'd80},
		   '{8'd0, 8'd4, 8'd8, 8'd12, 8'd16, 8'd20, 8'd24, 8'd28,
		     8'd32, 8'd40, 8'd48, 8'd56, 8'd64, 8'd72, 8'd80},
		   '{8'd0, 8'd16, 8'd24, 8'd28, 8'd32, 8'd40, 8'd48, 8'd56,
		     8'd64, 8'd72, 8'd80, 8'd88, 8'd96, 8'd112, 8'd128} },
		'{ '{8'd0, 8'd16, 8'd20, 8'd24, 8'd28, 8'd32, 8'd40, 8'd48,
		     8'd56, 8'd64, 8'd80, 8'd96, 8'd112, 8'd128, 8'd160},
		   '{8'd0, 8'd16, 8'd24, 8'd28, 8'd32, 8'd40, 8'd48, 8'd56,
		     8'd64, 8'd80, 8'd96, 8'd112, 8'd128, 8'd160, 8'd192},
		   '{8'd0, 8'd16, 8'd32, 8'd48, 8'd64, 8'd80, 8'd96, 8'd112,
		     8'd128, 8'd144, 8'd160, 8'd176, 8'd192, 8'd208, 8'd224} }
	};

	function automatic logic [26:0] recip_of(input div_sel_t sel);
		logic [26:0] r;
		unique case (sel)
			DIV_ONE: r = RECIP_ONE;
			DIV_TWO: r = RECIP_TWO;
			DIV_147: r = RECIP_147;
			default: r = RECIP_ONE;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hdl/mahd_in_if.sv @@
// Input channel of the MPEG audio header decoder: valid/ready plus one header item.
// Depends on no other file.
`timescale 1ns / 1ps
`default_nettype none

interface mahd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] header_word;
	logic [31:0] reference_word;
	logic [11:0] free_len;

	modport source (output valid, output header_word, output reference_word,
		output free_len, input ready);
	modport sink (input valid, input header_word, input reference_word,
		input free_len, output ready);
endinterface

`default_nettype wire

@@ hdl/mahd_out_if.sv @@
// Result channel of the MPEG audio header decoder: valid/ready plus one decoded item.
// Depends on no other file.
`timescale 1ns / 1ps
`default_nettype none

interface mahd_out_if;
	logic        valid;
	logic        ready;
	logic        header_ok;
	logic        matches_reference;
	logic [8:0]  bitrate_kbps;
	logic [15:0] sample_rate_hz;
	logic [10:0] samples_per_frame;
	logic [11:0] frame_length;
	logic [2:0]  padding_bytes;
	logic [1:0]  channel_count;
	logic [1:0]  layer_number;

	modport source (output valid, output header_ok, output matches_reference,
		output bitrate_kbps, output sample_rate_hz, output samples_per_frame,
		output frame_length, output padding_bytes, output channel_count,
		output layer_number, input ready);
	modport sink (input valid, input header_ok, input matches_reference,
		input bitrate_kbps, input sample_rate_hz, input samples_per_frame,
		input frame_length, input padding_bytes, input channel_count,
		input layer_number, output ready);
endinterface

`default_nettype wire

@@ hdl/mahd_decode.sv @@
// Field decode of one header: legality, reference match, table lookups and divisor choice.
// Depends on mahd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mahd_decode (
	input  wire logic [31:0]       header_word,
	input  wire logic [31:0]       reference_word,
	output mahd_pkg::hdr_info_t    info
);

	logic [7:0]  b0, b1, b2, b3, rb1, rb2;
	logic [1:0]  layer, sri, shift, lay_idx;
	logic [3:0]  bri, bri_idx, mult;
	logic        mpeg1, not25, layer1, lsf_l3, ok;
	logic [15:0] base_hz;
	logic [10:0] scale;
	mahd_pkg::div_sel_t div_sel;

	always_comb begin
		b0  = header_word[31:24];
		b1  = header_word[23:16];
		b2  = header_word[15:8];
		b3  = header_word[7:0];
		rb1 = reference_word[23:16];
		rb2 = reference_word[15:8];

		layer  = b1[2:1];
		mpeg1  = b1[3];
		not25  = b1[4];
		bri    = b2[7:4];
		sri    = b2[3:2];
		layer1 = (layer == mahd_pkg::LAYER_I);
		// Layer III of MPEG-2 or 2.5 carries half as many samples.
		lsf_l3 = (b1[3:1] == 3'b001);

		ok = (b0 == mahd_pkg::SYNC_BYTE) &&
			((b1[7:4] == mahd_pkg::SYNC_NIBBLE) || (b1[7:1] == mahd_pkg::MPEG25_L3)) &&
			(layer != 2'd0) && (bri != mahd_pkg::BAD_BRI) && (sri != mahd_pkg::BAD_SRI);

		lay_idx = (layer == 2'd0) ? 2'd0 : layer - 2'd1;
		bri_idx = (bri == mahd_pkg::BAD_BRI) ? 4'd0 : bri;
		shift   = {1'b0, ~mpeg1} + {1'b0, ~not25};

		unique case (sri)
			mahd_pkg::SRI_44K1: base_hz = mahd_pkg::HZ_44K1;
			mahd_pkg::SRI_32K:  base_hz = mahd_pkg::HZ_32K;
			default:            base_hz = mahd_pkg::HZ_48K;
		endcase

		// Samples*125 over the actual rate, as a multiple of 48000 over the base rate.
		if (layer1) begin
			mult = 4'd1 << shift;
		end else if (lsf_l3) begin
			mult = 4'd3 << (shift - 2'd1);
		end else begin
			mult = 4'd3 << shift;
		end

		unique case (sri)
			mahd_pkg::SRI_44K1: begin
				scale   = 11'(mult) * mahd_pkg::SCALE_44K1;
				div_sel = mahd_pkg::DIV_147;
			end
			mahd_pkg::SRI_32K: begin
				scale   = 11'(mult) * mahd_pkg::SCALE_32K;
				div_sel = mahd_pkg::DIV_TWO;
			end
			default: begin
				scale   = 11'(mult);
				div_sel = mahd_pkg::DIV_ONE;
			end
		endcase

		info.ok      = ok;
		info.layer1  = ok && layer1;
		info.scale   = scale;
		info.div_sel = div_sel;
		info.ref_match = ok && (((rb1 ^ b1) & mahd_pkg::MATCH_B1) == 8'd0) &&
			(((rb2 ^ b2) & mahd_pkg::MATCH_B2) == 8'd0) &&
			((bri == 4'd0) == (rb2[7:4] == 4'd0));
		info.kbps    = ok ? {mahd_pkg::HALF_KBPS[mpeg1][lay_idx][bri_idx], 1'b0} : 9'd0;
		info.hz      = ok ? (base_hz >> shift) : 16'd0;
		info.samples = !ok ? 11'd0 : layer1 ? mahd_pkg::SAMPLES_L1 :
			lsf_l3 ? mahd_pkg::SAMPLES_LSF : mahd_pkg::SAMPLES_STD;
		info.padding = (!ok || !b2[1]) ? 3'd0 : layer1 ? mahd_pkg::PAD_L1 : mahd_pkg::PAD_OTHER;
		info.chans   = !ok ? 2'd0 : (b3[7:6] == mahd_pkg::MONO_MODE) ? 2'd1 : 2'd2;
		info.layer_num = ok ? 2'(3'd4 - {1'b0, layer}) : 2'd0;
	end

endmodule

`default_nettype wire

@@ hdl/mahd_frame_len.sv @@
// Final frame length step: quotient extraction, Layer I slot alignment, free format fallback.
// Depends on mahd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mahd_frame_len (
	input  wire logic [mahd_pkg::PROD_W-1:0] prod,
	input  wire mahd_pkg::hdr_info_t         info,
	input  wire logic [11:0]                 free_len,
	output logic [11:0]                      frame_length
);

	logic [11:0] quot, aligned;

	always_comb begin
		// The quotient never exceeds twelve bits for a legal header.
		quot    = prod[mahd_pkg::RECIP_SHIFT +: 12];
		aligned = info.layer1 ? {quot[11:2], 2'b00} : quot;
		priority if (!info.ok) begin
			frame_length = 12'd0;
		end else if (aligned == 12'd0) begin
			frame_length = free_len;
		end else begin
			frame_length = aligned;
		end
	end

endmodule

`default_nettype wire

@@ hdl/mpeg_audio_header_decoder.sv @@
// An accepted item passes stages one to three into the output register, stage four.
// Throughput: one item per cycle while not stalled; the two multipliers (kbps by scale,
// then by reciprocal) each own a stage, so the four-stage pipeline has no feedback loop.
// Each stage holds its item while the stage after it is full and stalled.
// Reset clears the stage valid bits only; payload registers are not reset.
// Depends on mahd_pkg, mahd_in_if, mahd_out_if, mahd_decode and mahd_frame_len.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_audio_header_decoder (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mahd_in_if.sink     header,
	mahd_out_if.source  result
);

	mahd_pkg::hdr_info_t info_dec, info_s1, info_s2, info_s3, info_s4;
	logic [11:0] ffs_s1, ffs_s2, ffs_s3, len_s4, len_next;
	logic [mahd_pkg::X_W-1:0]    x_s2;
	logic [mahd_pkg::PROD_W-1:0] prod_s3;
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	// A stage may load when it is empty or its content moves on this cycle.
	assign adv4 = !v_s4 || result.ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign header.ready = adv1;

	mahd_decode u_decode (
		.header_word    (header.header_word),
		.reference_word (header.reference_word),
		.info           (info_dec)
	);

	mahd_frame_len u_frame_len (
		.prod         (prod_s3),
		.info         (info_s3),
		.free_len     (ffs_s3),
		.frame_length (len_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= header.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			info_s1 <= info_dec;
			ffs_s1  <= header.free_len;
		end
		if (adv2) begin
			info_s2 <= info_s1;
			ffs_s2  <= ffs_s1;
			x_s2    <= mahd_pkg::X_W'(info_s1.kbps) * mahd_pkg::X_W'(info_s1.scale);
		end
		if (adv3) begin
			info_s3 <= info_s2;
			ffs_s3  <= ffs_s2;
			prod_s3 <= mahd_pkg::PROD_W'(x_s2) *
				mahd_pkg::PROD_W'(mahd_pkg::recip_of(info_s2.div_sel));
		end
		if (adv4) begin
			info_s4 <= info_s3;
			len_s4  <= len_next;
		end
	end

	assign result.valid             = v_s4;
	assign result.header_ok         = info_s4.ok;
	assign result.matches_reference = info_s4.ref_match;
	assign result.bitrate_kbps      = info_s4.kbps;
	assign result.sample_rate_hz    = info_s4.hz;
	assign result.samples_per_frame = info_s4.samples;
	assign result.frame_length      = len_s4;
	assign result.padding_bytes     = info_s4.padding;
	assign result.channel_count     = info_s4.chans;
	assign result.layer_number      = info_s4.layer_num;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		header.valid && header.ready |=> v_s1)
		else $error("accepted item did not reach the first stage");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !info_s4.ok |-> (len_s4 == 12'd0) && (info_s4.kbps == 9'd0) &&
			(info_s4.hz == 16'd0) && !info_s4.ref_match)
		else $error("invalid header item carries non-zero results");

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && info_s4.ok |-> (info_s4.layer_num != 2'd0) && (info_s4.chans != 2'd0) &&
			(info_s4.hz != 16'd0))
		else $error("legal header item lost its layer, channels or rate");

	a_ok_samples: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && info_s4.ok |-> (info_s4.samples == mahd_pkg::SAMPLES_L1) ||
			(info_s4.samples == mahd_pkg::SAMPLES_LSF) ||
			(info_s4.samples == mahd_pkg::SAMPLES_STD))
		else $error("samples per frame out of set");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !adv3 |=> v_s3 && $stable(prod_s3))
		else $error("stalled stage three item was lost or changed");

endmodule

`default_nettype wire
